### rtl/core/assert_macros.svh
// Assertion shorthands shared by the checker files of this project.
// Each macro needs clk and arst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ole_pkg.sv
// Shared types and codes for the ordered list engine.
// Used by ordered_list_engine and its checker; no dependencies.
package ole_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;
	localparam int OP_W         = 3;
	localparam int ST_W         = 2;
	localparam int LEN_W        = 5;

	localparam logic [OP_W-1:0] OP_TAIL     = 3'd0;
	localparam logic [OP_W-1:0] OP_HEAD     = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
	localparam logic [OP_W-1:0] OP_CONTAINS = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic             found;
		logic [LEN_W-1:0] list_length;
		logic             is_empty;
	} rsp_t;

endpackage

### rtl/core/ordered_list_engine.sv
// Ordered list engine: bounded list of 32-bit values kept in insertion order.
// Depends on ole_pkg for the beat types and the operation and status codes.
//
// Usage:
//   req carries one operation (insert tail, insert head, delete first match,
//   contains, clear) and a value; rsp returns status, found, length and empty.
//   Every request beat produces exactly one response beat.
//   The entries live in a circular buffer with a head pointer, so both inserts
//   and clear need no walk: the response is valid in the cycle after the
//   request beat.
//   Delete and contains walk the list through one comparator, one entry per
//   cycle from a registered memory read; delete closes the gap by writing each
//   later entry back one slot as it streams past. The response is given once the
//   walk has covered every entry present at the request beat, but contains
//   stops early at its match.
//   One request is in flight at a time: req_stall is high after the request
//   beat until the response beat is taken.
//   rsp stays valid and unchanged while rsp_stall is high.
//   Reset empties the list at once; entries are not cleared, only count and head.
module ordered_list_engine #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ole_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ole_pkg::rsp_t rsp
);
	import ole_pkg::*;

	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = PW + 2;
	localparam logic [PW-1:0] LAST_PTR = PW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [DATA_W-1:0]   value_q;
	logic [CW-1:0]       count_q;
	logic [PW-1:0]       head_q;
	logic [CW-1:0]       rd_idx_q;
	logic [PW-1:0]       rd_ptr_q;
	logic                vld_s1;
	logic [CW-1:0]       idx_s1;
	logic [PW-1:0]       ptr_s1;
	logic [DATA_W-1:0]   rdata_s1;
	logic                hit_q;
	logic [PW-1:0]       dst_q;
	logic [ST_W-1:0]     status_q;
	logic                found_q;
	logic [DATA_W-1:0]   entry_store_q [CAPACITY];

	logic                full;
	logic [SW-1:0]       tail_sum;
	logic [PW-1:0]       tail_ptr;
	logic [PW-1:0]       head_prev;
	logic [PW-1:0]       rd_ptr_next;
	logic                rd_issue;
	logic                match_s1;
	logic                last_s1;
	logic                accept;
	logic                we;
	logic [PW-1:0]       wa;
	logic [DATA_W-1:0]   wd;

	assign accept    = (state_q == S_IDLE) && req_valid;
	assign full      = (count_q == FULL_CNT);
	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign tail_ptr  = (tail_sum >= SW'(CAPACITY)) ? PW'(tail_sum - SW'(CAPACITY))
	                                               : PW'(tail_sum);
	assign head_prev = (head_q == '0) ? LAST_PTR : head_q - PW'(1);
	assign rd_ptr_next = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
	assign rd_issue  = (state_q == S_WALK) && (rd_idx_q < count_q);
	assign match_s1  = vld_s1 && (rdata_s1 == value_q);
	assign last_s1   = vld_s1 && ((idx_s1 + CW'(1)) == count_q);

	// Memory write port: inserts from idle, gap closing during a delete walk
	always_comb begin
		we = 1'b0;
		wa = tail_ptr;
		wd = req.value;
		if (accept && !full && (req.op == OP_TAIL)) begin
			we = 1'b1;
		end else if (accept && !full && (req.op == OP_HEAD)) begin
			we = 1'b1;
			wa = head_prev;
		end else if ((state_q == S_WALK) && vld_s1 && hit_q && (op_q == OP_DELETE)) begin
			we = 1'b1;
			wa = dst_q;
			wd = rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			entry_store_q[wa] <= wd;
		end
		if (rd_issue) begin
			rdata_s1 <= entry_store_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_TAIL;
			value_q  <= '0;
			count_q  <= '0;
			head_q   <= '0;
			rd_idx_q <= '0;
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
			ptr_s1   <= '0;
			hit_q    <= 1'b0;
			dst_q    <= '0;
			status_q <= ST_OK;
			found_q  <= 1'b0;
		end else begin
			vld_s1 <= rd_issue;
			idx_s1 <= rd_idx_q;
			ptr_s1 <= rd_ptr_q;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q     <= req.op;
						value_q  <= req.value;
						rd_idx_q <= '0;
						rd_ptr_q <= head_q;
						hit_q    <= 1'b0;
						found_q  <= 1'b0;
						status_q <= ST_OK;
						state_q  <= S_DONE;
						unique case (req.op)
							OP_TAIL: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_HEAD: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
									head_q  <= head_prev;
								end
							end
							OP_DELETE, OP_CONTAINS: begin
								if (count_q == '0) begin
									status_q <= ST_MISSING;
								end else begin
									state_q <= S_WALK;
								end
							end
							OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					if (rd_issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
						rd_ptr_q <= rd_ptr_next;
					end
					// after the hit, each streamed entry moves into the slot before it
					if (vld_s1 && hit_q) begin
						dst_q <= ptr_s1;
					end
					if (last_s1) begin
						state_q <= S_DONE;
						if (hit_q || match_s1) begin
							found_q <= 1'b1;
							if (op_q == OP_DELETE) begin
								count_q <= count_q - CW'(1);
							end
						end else begin
							status_q <= ST_MISSING;
						end
					end
					if (match_s1 && !hit_q) begin
						hit_q <= 1'b1;
						dst_q <= ptr_s1;
						if (op_q == OP_CONTAINS) begin
							found_q <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall        = (state_q != S_IDLE);
	assign rsp_valid        = (state_q == S_DONE);
	assign rsp.status       = status_q;
	assign rsp.found        = found_q;
	assign rsp.list_length  = LEN_W'(count_q);
	assign rsp.is_empty     = (count_q == '0);

endmodule

### rtl/core/ole_checker.sv
// Port-level checker for ordered_list_engine, bound to every instance.
// Depends on ole_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ole_checker #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input ole_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input ole_pkg::rsp_t rsp
);
	import ole_pkg::*;

	localparam logic EXACT_LEN = (CAPACITY < 32);

	`ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response beat changed while stalled")
	`ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "request taken while another is in flight")
	`ASSERT_IMPL(a_found_ok, rsp_valid && rsp.found, rsp.status == ST_OK, "found set with a failing status")
	`ASSERT_IMPL(a_empty_len, rsp_valid && EXACT_LEN, rsp.is_empty == (rsp.list_length == '0), "empty flag disagrees with length")
	`ASSERT_IMPL(a_full_len, rsp_valid && EXACT_LEN && (rsp.status == ST_FULL), rsp.list_length == LEN_W'(CAPACITY), "insert refused below capacity")

endmodule

bind ordered_list_engine ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker (.*);
